// ===== rtl/owbm_pkg.sv =====
// Package of the 1-Wire bus master: widths, command and register codes,
// bus phase encoding, configuration and result structures.
// No dependencies.
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int unsigned BitsPerByteDef = 8;
  localparam int unsigned TickW          = 12;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned ModeW          = 3;
  localparam int unsigned CfgIdxW        = 3;

  // Command codes carried in the mode field.
  localparam logic [ModeW-1:0] ModeTick    = 3'd0;
  localparam logic [ModeW-1:0] ModeWrite   = 3'd1;
  localparam logic [ModeW-1:0] ModeRead    = 3'd2;
  localparam logic [ModeW-1:0] ModeReset   = 3'd3;
  localparam logic [ModeW-1:0] ModePull    = 3'd4;
  localparam logic [ModeW-1:0] ModeRelease = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgShortLow    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLongLow     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleDelay = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgReadRecov   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgResetLow    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgResetWait   = 3'd5;

  // Register reset values.
  localparam logic [TickW-1:0] ShortLowRst    = 12'd2;
  localparam logic [TickW-1:0] LongLowRst     = 12'd80;
  localparam logic [TickW-1:0] SampleDelayRst = 12'd12;
  localparam logic [TickW-1:0] ReadRecovRst   = 12'd66;
  localparam logic [TickW-1:0] ResetLowRst    = 12'd600;
  localparam logic [TickW-1:0] ResetWaitRst   = 12'd600;

  typedef enum logic [7:0] {
    PhIdle   = 8'b0000_0001,
    PhWrLow  = 8'b0000_0010,
    PhWrRel  = 8'b0000_0100,
    PhRdLow  = 8'b0000_1000,
    PhRdWait = 8'b0001_0000,
    PhRdRec  = 8'b0010_0000,
    PhRsLow  = 8'b0100_0000,
    PhRsWait = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] short_low;
    logic [TickW-1:0] long_low;
    logic [TickW-1:0] sample_delay;
    logic [TickW-1:0] read_recovery;
    logic [TickW-1:0] reset_low;
    logic [TickW-1:0] reset_wait;
  } cfg_t;

  // Result fields, lowest bit last, matching the output beat layout.
  typedef struct packed {
    logic [ByteW-1:0] read_value;
    logic             done_res;
    logic             busy_res;
    logic             drive_strong_high;
    logic             drive_low;
  } res_t;

  // A programmed count of zero is treated as one tick.
  function automatic logic [TickW-1:0] ticks_of(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

// ===== rtl/owbm_engine.sv =====
// Bus timing state machine of the 1-Wire bus master: phase, tick counter,
// bit counter and shift register, advanced once per accepted beat.
// Depends on owbm_pkg.
`timescale 1ns / 1ps

module owbm_engine #(
  parameter int unsigned BitsPerByte = owbm_pkg::BitsPerByteDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [owbm_pkg::ModeW-1:0]    mode_i,
  input  logic [owbm_pkg::ByteW-1:0]    write_value_i,
  input  logic                          line_level_i,
  input  owbm_pkg::cfg_t                cfg_i,
  output owbm_pkg::res_t                res_o
);

  localparam int unsigned BitsW = $clog2(BitsPerByte + 1);

  owbm_pkg::phase_e                 phase_q, phase_d;
  logic [BitsW-1:0]                 bits_q, bits_d;
  logic [owbm_pkg::ByteW-1:0]       shift_q, shift_d;
  logic [owbm_pkg::TickW-1:0]       tick_q, tick_d;
  logic                             pull_q, pull_d;
  logic [owbm_pkg::ByteW-1:0]       last_q, last_d;
  logic                             done;

  always_comb begin
    logic [owbm_pkg::TickW-1:0] tick_dec;
    logic [BitsW-1:0]           bits_dec;
    logic [owbm_pkg::ByteW-1:0] shifted;
    phase_d  = phase_q;
    bits_d   = bits_q;
    shift_d  = shift_q;
    tick_d   = tick_q;
    pull_d   = pull_q;
    last_d   = last_q;
    done     = 1'b0;
    tick_dec = tick_q - owbm_pkg::TickW'(1);
    bits_dec = bits_q - BitsW'(1);
    shifted  = shift_q >> 1;
    if (phase_q == owbm_pkg::PhIdle) begin
      case (mode_i)
        owbm_pkg::ModeWrite: begin
          pull_d  = 1'b0;
          shift_d = write_value_i;
          bits_d  = BitsW'(BitsPerByte);
          phase_d = owbm_pkg::PhWrLow;
          tick_d  = owbm_pkg::ticks_of(write_value_i[0] ? cfg_i.short_low : cfg_i.long_low);
        end
        owbm_pkg::ModeRead: begin
          pull_d  = 1'b0;
          shift_d = '0;
          bits_d  = BitsW'(BitsPerByte);
          phase_d = owbm_pkg::PhRdLow;
          tick_d  = owbm_pkg::ticks_of(cfg_i.short_low);
        end
        owbm_pkg::ModeReset: begin
          pull_d  = 1'b0;
          phase_d = owbm_pkg::PhRsLow;
          tick_d  = owbm_pkg::ticks_of(cfg_i.reset_low);
        end
        owbm_pkg::ModePull:    pull_d = 1'b1;
        owbm_pkg::ModeRelease: pull_d = 1'b0;
        default: ;
      endcase
    end else if (!(mode_i inside {[owbm_pkg::ModeWrite:owbm_pkg::ModeRelease]})) begin
      tick_d = tick_dec;
      if (tick_dec == '0) begin
        case (phase_q)
          owbm_pkg::PhWrLow: begin
            phase_d = owbm_pkg::PhWrRel;
            tick_d  = owbm_pkg::ticks_of(shift_q[0] ? cfg_i.long_low : cfg_i.short_low);
          end
          owbm_pkg::PhWrRel: begin
            shift_d = shifted;
            bits_d  = bits_dec;
            if (bits_dec == '0) begin
              phase_d = owbm_pkg::PhIdle;
              done    = 1'b1;
            end else begin
              phase_d = owbm_pkg::PhWrLow;
              tick_d  = owbm_pkg::ticks_of(shifted[0] ? cfg_i.short_low : cfg_i.long_low);
            end
          end
          owbm_pkg::PhRdLow: begin
            phase_d = owbm_pkg::PhRdWait;
            tick_d  = owbm_pkg::ticks_of(cfg_i.sample_delay);
          end
          owbm_pkg::PhRdWait: begin
            shift_d = {line_level_i | shift_q[owbm_pkg::ByteW-1], shift_q[owbm_pkg::ByteW-2:0]};
            phase_d = owbm_pkg::PhRdRec;
            tick_d  = owbm_pkg::ticks_of(cfg_i.read_recovery);
          end
          owbm_pkg::PhRdRec: begin
            bits_d = bits_dec;
            if (bits_dec == '0) begin
              last_d  = shift_q;
              phase_d = owbm_pkg::PhIdle;
              done    = 1'b1;
            end else begin
              shift_d = shifted;
              phase_d = owbm_pkg::PhRdLow;
              tick_d  = owbm_pkg::ticks_of(cfg_i.short_low);
            end
          end
          owbm_pkg::PhRsLow: begin
            phase_d = owbm_pkg::PhRsWait;
            tick_d  = owbm_pkg::ticks_of(cfg_i.reset_wait);
          end
          default: begin
            phase_d = owbm_pkg::PhIdle;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o.drive_low         = (phase_d == owbm_pkg::PhWrLow) || (phase_d == owbm_pkg::PhRdLow) ||
                              (phase_d == owbm_pkg::PhRsLow);
    res_o.drive_strong_high = pull_d;
    res_o.busy_res          = (phase_d != owbm_pkg::PhIdle);
    res_o.done_res          = done;
    res_o.read_value        = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PhIdle;
      bits_q  <= '0;
      shift_q <= '0;
      tick_q  <= '0;
      pull_q  <= 1'b0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      pull_q  <= pull_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== rtl/one_wire_bus_master_unit.sv =====
// Top level of the 1-Wire bus master: stream ports, timing registers and the
// output register. Depends on owbm_pkg and owbm_engine.
`timescale 1ns / 1ps

// Each input beat is one microsecond tick or one command, and the block takes
// one beat per clock cycle. The bus state after that beat appears as one
// output beat, held in an output register, in the cycle after acceptance; the
// input side keeps accepting while the output register is empty or being
// read, so only back-pressure on the output side slows the stream. Timing
// registers are written through the configuration channel, which is always
// ready; writes to unused indexes are ignored.
module one_wire_bus_master_unit #(
  parameter int unsigned BitsPerByte = owbm_pkg::BitsPerByteDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Bits: write_value [7:0], line_level [8], zeros above.
  input  logic [15:0]                   s_axis_tdata,
  // Bits: mode [2:0].
  input  logic [owbm_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Bits: drive_low [0], drive_strong_high [1], busy_res [2], done_res [3],
  // read_value [11:4], zeros above.
  output logic [15:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owbm_pkg::TickW-1:0]    cfg_data_i
);

  owbm_pkg::cfg_t cfg_q, cfg_d;
  owbm_pkg::res_t res_q, res_d;
  logic           m_valid_q, m_valid_d;
  logic           accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_valid_d     = accept || (m_valid_q && !m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q};

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        owbm_pkg::CfgShortLow:    cfg_d.short_low     = cfg_data_i;
        owbm_pkg::CfgLongLow:     cfg_d.long_low      = cfg_data_i;
        owbm_pkg::CfgSampleDelay: cfg_d.sample_delay  = cfg_data_i;
        owbm_pkg::CfgReadRecov:   cfg_d.read_recovery = cfg_data_i;
        owbm_pkg::CfgResetLow:    cfg_d.reset_low     = cfg_data_i;
        owbm_pkg::CfgResetWait:   cfg_d.reset_wait    = cfg_data_i;
        default: ;
      endcase
    end
  end

  owbm_engine #(
    .BitsPerByte(BitsPerByte)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .mode_i       (s_axis_tuser),
    .write_value_i(s_axis_tdata[7:0]),
    .line_level_i (s_axis_tdata[8]),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_low     <= owbm_pkg::ShortLowRst;
      cfg_q.long_low      <= owbm_pkg::LongLowRst;
      cfg_q.sample_delay  <= owbm_pkg::SampleDelayRst;
      cfg_q.read_recovery <= owbm_pkg::ReadRecovRst;
      cfg_q.reset_low     <= owbm_pkg::ResetLowRst;
      cfg_q.reset_wait    <= owbm_pkg::ResetWaitRst;
      m_valid_q           <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule
